@@ sv/mbl_pkg.sv @@
`default_nettype none

package mbl_pkg;

	localparam int CHANNELS_DEF  = 3;
	localparam int MAX_ORDER_DEF = 4;

	localparam int CH_W     = 2;
	localparam int SMP_W    = 32;
	localparam int COEF_W   = 32;
	localparam int HIST_W   = 48;
	localparam int IDX_W    = 3;
	localparam int GPROD_W  = 64;
	localparam int LPROD_W  = 49;
	localparam int WIDE_W   = 80;
	localparam int TERM_W   = 52;
	localparam int SUM_W    = 55;
	localparam int ACC_W    = 56;
	localparam int NUM_FB   = 4;
	localparam int TAP_CNT_W = 3;
	localparam int WGT_W    = 3;

	typedef enum logic [1:0] {
		ORD_BYPASS = 2'd0,
		ORD_FIRST  = 2'd1,
		ORD_SECOND = 2'd2,
		ORD_FOURTH = 2'd3
	} order_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ORDER = 3'd0,
		REG_GAIN  = 3'd1,
		REG_FB0   = 3'd2,
		REG_FB1   = 3'd3,
		REG_FB2   = 3'd4,
		REG_FB3   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		order_t                           order;
		logic [COEF_W-1:0]                gain;
		logic [NUM_FB-1:0][COEF_W-1:0]    fb;
	} cfg_t;

	typedef struct packed {
		logic            act_s1;
		logic            act_s2;
		logic            act_s3;
		logic [CH_W-1:0] ch_s1;
		logic [CH_W-1:0] ch_s2;
		logic [CH_W-1:0] ch_s3;
	} busy_t;

	function automatic logic [TAP_CNT_W-1:0] tap_count(order_t o);
		logic [TAP_CNT_W-1:0] n;
		unique case (o)
			ORD_BYPASS: n = 3'd0;
			ORD_FIRST:  n = 3'd1;
			ORD_SECOND: n = 3'd2;
			ORD_FOURTH: n = 3'd4;
			default:    n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [WGT_W-1:0] tap_weight(order_t o, logic [1:0] k);
		logic [WGT_W-1:0] wt;
		wt = 3'd0;
		unique case (o)
			ORD_FIRST:  wt = (k == 2'd0) ? 3'd1 : 3'd0;
			ORD_SECOND: begin
				if (k == 2'd0)
					wt = 3'd2;
				else if (k == 2'd1)
					wt = 3'd1;
			end
			ORD_FOURTH: begin
				unique case (k)
					2'd0:    wt = 3'd4;
					2'd1:    wt = 3'd6;
					2'd2:    wt = 3'd4;
					2'd3:    wt = 3'd1;
					default: wt = 3'd0;
				endcase
			end
			default:    wt = 3'd0;
		endcase
		return wt;
	endfunction

endpackage

`default_nettype wire

@@ sv/mbl_cfg_regs.sv @@
`default_nettype none

module mbl_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [mbl_pkg::IDX_W-1:0]  cfg_idx,
	input  wire logic [mbl_pkg::COEF_W-1:0] cfg_wdata,
	output mbl_pkg::cfg_t                   cfg
);

	mbl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (mbl_pkg::cfg_reg_t'(cfg_idx))
				mbl_pkg::REG_ORDER: cfg_q.order <= mbl_pkg::order_t'(cfg_wdata[1:0]);
				mbl_pkg::REG_GAIN:  cfg_q.gain  <= cfg_wdata;
				mbl_pkg::REG_FB0:   cfg_q.fb[0] <= cfg_wdata;
				mbl_pkg::REG_FB1:   cfg_q.fb[1] <= cfg_wdata;
				mbl_pkg::REG_FB2:   cfg_q.fb[2] <= cfg_wdata;
				mbl_pkg::REG_FB3:   cfg_q.fb[3] <= cfg_wdata;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/mbl_hist_mem.sv @@
`default_nettype none

module mbl_hist_mem #(
	parameter int CHANNELS  = mbl_pkg::CHANNELS_DEF,
	parameter int MAX_ORDER = mbl_pkg::MAX_ORDER_DEF,
	localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       rd_en,
	input  wire logic [ADDR_W-1:0]                          rd_addr,
	output logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0]       rd_row,
	output logic                                            rd_vld,
	input  wire logic                                       wr_en,
	input  wire logic [ADDR_W-1:0]                          wr_addr,
	input  wire logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0]  wr_row
);

	logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0]                       vld_q;
	logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0] rd_row_q;
	logic                                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		if (rd_en)
			rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_row = rd_row_q;
	assign rd_vld = rd_vld_q;

endmodule

`default_nettype wire

@@ sv/mbl_datapath.sv @@
`default_nettype none

module mbl_datapath #(
	parameter int MAX_ORDER = mbl_pkg::MAX_ORDER_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       adv,
	input  wire logic                                       in_acc,
	input  wire logic                                       in_act,
	input  wire logic [mbl_pkg::CH_W-1:0]                   in_ch,
	input  wire logic [mbl_pkg::SMP_W-1:0]                  in_x,
	input  wire mbl_pkg::cfg_t                              cfg,
	input  wire logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0]  rd_row,
	input  wire logic                                       rd_vld,
	output logic                                            wr_en,
	output logic [mbl_pkg::CH_W-1:0]                        wr_ch,
	output logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0]       wr_row,
	output mbl_pkg::busy_t                                  busy,
	output logic                                            push_valid,
	output logic [mbl_pkg::SMP_W-1:0]                       push_data
);

	localparam int HW = mbl_pkg::HIST_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic act_s1, act_s2, act_s3, act_s4;
	logic [mbl_pkg::CH_W-1:0] ch_s1, ch_s2, ch_s3;
	logic [mbl_pkg::SMP_W-1:0] x_s1, x_s2, x_s3, x_s4;

	logic signed [HW-1:0]                     h_s1 [MAX_ORDER];
	logic signed [mbl_pkg::GPROD_W-1:0]       gp_s1;
	logic signed [mbl_pkg::GPROD_W-1:0]       ap_s1 [MAX_ORDER];
	logic signed [mbl_pkg::LPROD_W-1:0]       bp_s1 [MAX_ORDER];

	logic signed [HW-1:0]                     h_s2 [MAX_ORDER];
	logic signed [mbl_pkg::GPROD_W-1:0]       gp_s2;
	logic signed [mbl_pkg::GPROD_W-1:0]       ap_s2 [MAX_ORDER];
	logic signed [mbl_pkg::LPROD_W-1:0]       bp_s2 [MAX_ORDER];
	logic signed [mbl_pkg::TERM_W-1:0]        ft_s2 [MAX_ORDER];
	logic signed [mbl_pkg::SUM_W-1:0]         bn_s2;

	logic signed [HW-1:0]                     h_s3 [MAX_ORDER];
	logic signed [mbl_pkg::TERM_W-1:0]        gt_s3;
	logic signed [mbl_pkg::TERM_W-1:0]        ft_s3 [MAX_ORDER];
	logic signed [mbl_pkg::SUM_W-1:0]         bn_s3;
	logic signed [HW-1:0]                     w_s3;

	logic signed [HW-1:0]                     w_s4;
	logic signed [mbl_pkg::SUM_W-1:0]         bn_s4;

	logic [mbl_pkg::TAP_CNT_W-1:0]            taps;

	assign taps = mbl_pkg::tap_count(cfg.order);

	// stage 1: history row arrives, form partial products
	always_comb begin
		for (int k = 0; k < MAX_ORDER; k++) begin
			h_s1[k]  = rd_vld ? $signed(rd_row[k]) : '0;
			ap_s1[k] = $signed(cfg.fb[k]) * $signed(h_s1[k][HW-1:16]);
			bp_s1[k] = $signed(cfg.fb[k]) * $signed({1'b0, h_s1[k][15:0]});
		end
		gp_s1 = $signed(cfg.gain) * $signed(x_s1);
	end

	// stage 2: recombine partial products, weight history
	always_comb begin
		logic signed [mbl_pkg::WIDE_W-1:0] p;
		bn_s2 = '0;
		for (int k = 0; k < MAX_ORDER; k++) begin
			p = $signed({ap_s2[k], 16'b0}) + mbl_pkg::WIDE_W'(bp_s2[k]);
			ft_s2[k] = (k < 32'(taps)) ? p[mbl_pkg::WIDE_W-1:28] : '0;
			bn_s2 = bn_s2 + mbl_pkg::SUM_W'(h_s2[k]) *
				$signed({1'b0, mbl_pkg::tap_weight(cfg.order, 2'(k))});
		end
	end

	// stage 3: new history word, saturated to the word width
	always_comb begin
		logic signed [mbl_pkg::SUM_W-1:0] sum;
		sum = mbl_pkg::SUM_W'(gt_s3);
		for (int k = 0; k < MAX_ORDER; k++)
			sum = sum + mbl_pkg::SUM_W'(ft_s3[k]);
		if (sum[mbl_pkg::SUM_W-1:HW-1] == {(mbl_pkg::SUM_W-HW+1){sum[mbl_pkg::SUM_W-1]}})
			w_s3 = sum[HW-1:0];
		else
			w_s3 = {sum[mbl_pkg::SUM_W-1], {(HW-1){!sum[mbl_pkg::SUM_W-1]}}};
	end

	always_comb begin
		wr_row[0] = w_s3;
		for (int k = 1; k < MAX_ORDER; k++)
			wr_row[k] = h_s3[k-1];
	end

	assign wr_en = adv && v_s3 && act_s3;
	assign wr_ch = ch_s3;

	// stage 4: binomial sum, scale and saturate; inactive beats pass the input sample
	always_comb begin
		logic signed [mbl_pkg::ACC_W-1:0] acc;
		logic signed [mbl_pkg::ACC_W-17:0] y;
		logic [mbl_pkg::SMP_W-1:0]          ysat;
		acc = mbl_pkg::ACC_W'(w_s4) + mbl_pkg::ACC_W'(bn_s4);
		y   = acc[mbl_pkg::ACC_W-1:16];
		if (y[mbl_pkg::ACC_W-17:mbl_pkg::SMP_W-1] ==
				{(mbl_pkg::ACC_W-16-mbl_pkg::SMP_W+1){y[mbl_pkg::ACC_W-17]}})
			ysat = y[mbl_pkg::SMP_W-1:0];
		else
			ysat = {y[mbl_pkg::ACC_W-17], {(mbl_pkg::SMP_W-1){!y[mbl_pkg::ACC_W-17]}}};
		push_data = act_s4 ? ysat : x_s4;
	end

	assign push_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
			act_s3 <= 1'b0;
			act_s4 <= 1'b0;
		end else if (adv) begin
			v_s1   <= in_acc;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			act_s1 <= in_acc && in_act;
			act_s2 <= v_s1 && act_s1;
			act_s3 <= v_s2 && act_s2;
			act_s4 <= v_s3 && act_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1 <= in_ch;
			x_s1  <= in_x;
			ch_s2 <= ch_s1;
			x_s2  <= x_s1;
			gp_s2 <= gp_s1;
			ch_s3 <= ch_s2;
			x_s3  <= x_s2;
			gt_s3 <= gp_s2[mbl_pkg::GPROD_W-1:12];
			bn_s3 <= bn_s2;
			x_s4  <= x_s3;
			w_s4  <= w_s3;
			bn_s4 <= bn_s3;
			for (int k = 0; k < MAX_ORDER; k++) begin
				h_s2[k]  <= h_s1[k];
				ap_s2[k] <= ap_s1[k];
				bp_s2[k] <= bp_s1[k];
				h_s3[k]  <= h_s2[k];
				ft_s3[k] <= ft_s2[k];
			end
		end
	end

	assign busy.act_s1 = v_s1 && act_s1;
	assign busy.act_s2 = v_s2 && act_s2;
	assign busy.act_s3 = v_s3 && act_s3;
	assign busy.ch_s1  = ch_s1;
	assign busy.ch_s2  = ch_s2;
	assign busy.ch_s3  = ch_s3;

endmodule

`default_nettype wire

@@ sv/mbl_out_skid.sv @@
`default_nettype none

module mbl_out_skid (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [mbl_pkg::SMP_W-1:0] push_data,
	output logic                           room,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [mbl_pkg::SMP_W-1:0]      filtered
);

	logic [1:0]                cnt_q;
	logic [mbl_pkg::SMP_W-1:0] head_q, tail_q;
	logic                      pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q != 2'd2) || pop;
	assign filtered  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (push && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !push)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		unique case (cnt_q)
			2'd0: begin
				if (push)
					head_q <= push_data;
			end
			2'd1: begin
				if (push && pop)
					head_q <= push_data;
				else if (push)
					tail_q <= push_data;
			end
			2'd2: begin
				if (pop) begin
					head_q <= tail_q;
					if (push)
						tail_q <= push_data;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/multichannel_bessel_lowpass_iir_core.sv @@
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  channel[1:0], sample[31:0]
// output    out_valid / out_stall filtered[31:0]
// config    cfg_wen              cfg_idx[2:0], cfg_wdata[31:0]
//
// Four pipeline stages and a two-beat output queue; across channels the core takes
// one beat per cycle while the output queue has room and no same-channel beat holds it.
// A filtered beat waits while an earlier filtered beat of the same channel is in
// stages 1 to 3, the history memory read-modify-write loop.
// Reset clears the row valid bits; rows never written read as zero history.
// The pipeline freezes only when the output queue is full and out_stall is high.

module multichannel_bessel_lowpass_iir_core #(
	parameter int CHANNELS  = mbl_pkg::CHANNELS_DEF,
	parameter int MAX_ORDER = mbl_pkg::MAX_ORDER_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [mbl_pkg::CH_W-1:0]   channel,
	input  wire logic [mbl_pkg::SMP_W-1:0]  sample,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [mbl_pkg::SMP_W-1:0]       filtered,
	input  wire logic                       cfg_wen,
	input  wire logic [mbl_pkg::IDX_W-1:0]  cfg_idx,
	input  wire logic [mbl_pkg::COEF_W-1:0] cfg_wdata
);

	localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	mbl_pkg::cfg_t  cfg;
	mbl_pkg::busy_t busy;

	logic                                      adv;
	logic                                      room;
	logic                                      in_act;
	logic                                      hazard;
	logic                                      in_acc;
	logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0] rd_row;
	logic                                      rd_vld;
	logic                                      wr_en;
	logic [mbl_pkg::CH_W-1:0]                  wr_ch;
	logic [MAX_ORDER-1:0][mbl_pkg::HIST_W-1:0] wr_row;
	logic                                      push_valid;
	logic [mbl_pkg::SMP_W-1:0]                 push_data;

	assign in_act = (cfg.order != mbl_pkg::ORD_BYPASS)
		&& (32'(mbl_pkg::tap_count(cfg.order)) <= MAX_ORDER)
		&& (32'(channel) < CHANNELS);

	assign hazard = in_act && (
		(busy.act_s1 && (busy.ch_s1 == channel)) ||
		(busy.act_s2 && (busy.ch_s2 == channel)) ||
		(busy.act_s3 && (busy.ch_s3 == channel)));

	assign adv      = room;
	assign in_stall = !adv || hazard;
	assign in_acc   = in_valid && !in_stall;

	mbl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mbl_hist_mem #(
		.CHANNELS  (CHANNELS),
		.MAX_ORDER (MAX_ORDER)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc && in_act),
		.rd_addr (ADDR_W'(channel)),
		.rd_row  (rd_row),
		.rd_vld  (rd_vld),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(wr_ch)),
		.wr_row  (wr_row)
	);

	mbl_datapath #(
		.MAX_ORDER (MAX_ORDER)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_acc     (in_acc),
		.in_act     (in_act),
		.in_ch      (channel),
		.in_x       (sample),
		.cfg        (cfg),
		.rd_row     (rd_row),
		.rd_vld     (rd_vld),
		.wr_en      (wr_en),
		.wr_ch      (wr_ch),
		.wr_row     (wr_row),
		.busy       (busy),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	mbl_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && push_valid),
		.push_data (push_data),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered)
	);

`ifndef SYNTHESIS
	a_no_overlap_s1_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(busy.act_s1 && busy.act_s2) |-> (busy.ch_s1 != busy.ch_s2))
		else $error("two active beats of one channel in stages 1 and 2");

	a_no_overlap_s1_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(busy.act_s1 && busy.act_s3) |-> (busy.ch_s1 != busy.ch_s3))
		else $error("two active beats of one channel in stages 1 and 3");

	a_frozen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !adv) |=> (push_valid && $stable(push_data)))
		else $error("last stage moved while pipeline frozen");

	a_write_needs_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !(in_acc && in_act && (channel == wr_ch)))
		else $error("history read of a row being written");
`endif

endmodule

`default_nettype wire

@@ tb/multichannel_bessel_lowpass_iir_core_test.sv @@
`timescale 1ns / 100ps

module multichannel_bessel_lowpass_iir_core_test;

	localparam int NCH         = mbl_pkg::CHANNELS_DEF;
	localparam int NTAP        = mbl_pkg::MAX_ORDER_DEF;
	localparam int ITEM_TARGET = 1850;
	localparam int IDLE_LIMIT  = 5000;

	localparam logic signed [127:0] HIST_HI = 128'sh7FFF_FFFF_FFFF;
	localparam logic signed [127:0] HIST_LO = -HIST_HI - 1;
	localparam logic signed [127:0] OUT_HI  = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] OUT_LO  = -OUT_HI - 1;

	localparam logic [31:0] G1_Q   = 32'd18118596;
	localparam logic [31:0] A1_Q   = 32'd232198263;
	localparam logic [31:0] G2_Q   = 32'd6035787;
	localparam logic [31:0] A21_Q  = 32'd391790760;
	localparam logic [31:0] A22_Q  = -32'sd147498447;
	localparam logic [31:0] G4_Q   = 32'd2658364;
	localparam logic [31:0] A41_Q  = 32'd471239973;
	localparam logic [31:0] A42_Q  = -32'sd357558229;
	localparam logic [31:0] A43_Q  = 32'd131620104;
	localparam logic [31:0] A44_Q  = -32'sd19400207;

	typedef struct packed {
		logic [mbl_pkg::CH_W-1:0]  ch;
		logic [mbl_pkg::SMP_W-1:0] x;
	} sample_beat_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [mbl_pkg::CH_W-1:0] channel = '0;
	logic [mbl_pkg::SMP_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [mbl_pkg::SMP_W-1:0] filtered;
	logic cfg_wen = 1'b0;
	logic [mbl_pkg::IDX_W-1:0] cfg_idx = '0;
	logic [mbl_pkg::COEF_W-1:0] cfg_wdata = '0;

	mbl_pkg::order_t cur_order = mbl_pkg::ORD_BYPASS;
	logic signed [31:0] gain_q = '0;
	logic signed [31:0] fb_q [NTAP];
	logic signed [47:0] hist [NCH][NTAP];

	sample_beat_t samples_pending [$];
	logic [mbl_pkg::SMP_W-1:0] filtered_due [$];
	sample_beat_t drv_beat;
	logic [mbl_pkg::SMP_W-1:0] want;

	int burst_left = 8;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int unsigned stall_tick = 0;
	int idle_cycles = 0;
	int beats_in = 0;
	int beats_out = 0;
	int errors = 0;
	int bypass_cnt = 0;
	int oor_cnt = 0;
	int ord_cnt [4] = '{0, 0, 0, 0};
	int phases = 0;
	int queued = 0;

	multichannel_bessel_lowpass_iir_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel(channel),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [mbl_pkg::SMP_W-1:0] filter_sample(
			logic [mbl_pkg::CH_W-1:0] ch, logic signed [31:0] x);
		logic signed [127:0] g_w, x_w, c_w, h_w, w_acc, y_acc;
		int wts [NTAP];
		int ntaps;
		case (cur_order)
			mbl_pkg::ORD_FIRST: begin
				ntaps = 1;
				wts = '{1, 0, 0, 0};
			end
			mbl_pkg::ORD_SECOND: begin
				ntaps = 2;
				wts = '{2, 1, 0, 0};
			end
			mbl_pkg::ORD_FOURTH: begin
				ntaps = 4;
				wts = '{4, 6, 4, 1};
			end
			default: begin
				ntaps = 0;
				wts = '{0, 0, 0, 0};
			end
		endcase
		if (ch >= NCH) begin
			oor_cnt++;
			return x;
		end
		if (cur_order == mbl_pkg::ORD_BYPASS || ntaps > NTAP) begin
			bypass_cnt++;
			return x;
		end
		ord_cnt[cur_order]++;
		g_w = gain_q;
		x_w = x;
		w_acc = (g_w * x_w) >>> 12;
		for (int k = 0; k < ntaps; k++) begin
			c_w = fb_q[k];
			h_w = hist[ch][k];
			w_acc = w_acc + ((c_w * h_w) >>> 28);
		end
		if (w_acc > HIST_HI)
			w_acc = HIST_HI;
		if (w_acc < HIST_LO)
			w_acc = HIST_LO;
		y_acc = w_acc;
		for (int k = 0; k < ntaps; k++) begin
			h_w = hist[ch][k];
			y_acc = y_acc + wts[k] * h_w;
		end
		y_acc = y_acc >>> 16;
		if (y_acc > OUT_HI)
			y_acc = OUT_HI;
		if (y_acc < OUT_LO)
			y_acc = OUT_LO;
		for (int k = NTAP - 1; k > 0; k--)
			hist[ch][k] = hist[ch][k - 1];
		hist[ch][0] = w_acc[47:0];
		return y_acc[31:0];
	endfunction

	task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		errors++;
		$display("mismatch at output beat %0d: %s, got %h want %h",
			beats_out, what, got, exp_val);
	endtask

	task automatic write_reg(mbl_pkg::cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			mbl_pkg::REG_ORDER: cur_order = mbl_pkg::order_t'(val[1:0]);
			mbl_pkg::REG_GAIN:  gain_q = val;
			mbl_pkg::REG_FB0:   fb_q[0] = val;
			mbl_pkg::REG_FB1:   fb_q[1] = val;
			mbl_pkg::REG_FB2:   fb_q[2] = val;
			mbl_pkg::REG_FB3:   fb_q[3] = val;
			default:   ;
		endcase
	endtask

	task automatic set_config(mbl_pkg::order_t o, logic [31:0] g, logic [31:0] f0,
			logic [31:0] f1, logic [31:0] f2, logic [31:0] f3);
		write_reg(mbl_pkg::REG_ORDER, {30'd0, o});
		write_reg(mbl_pkg::REG_GAIN, g);
		write_reg(mbl_pkg::REG_FB0, f0);
		write_reg(mbl_pkg::REG_FB1, f1);
		write_reg(mbl_pkg::REG_FB2, f2);
		write_reg(mbl_pkg::REG_FB3, f3);
		@(posedge clk);
		cfg_wen <= 1'b0;
		phases++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (samples_pending.size() != 0 || in_valid || filtered_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic queue_beat(logic [mbl_pkg::CH_W-1:0] ch, logic [31:0] x);
		samples_pending.push_back('{ch: ch, x: x});
		queued++;
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			default: return 32'h1000_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return pick_extreme();
			1, 2: return $urandom;
			default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [mbl_pkg::CH_W-1:0] rand_channel();
		if ($urandom_range(0, 19) == 0)
			return 2'd3;
		return 2'($urandom_range(0, NCH - 1));
	endfunction

	// Send beats in bursts; predict at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			channel <= '0;
			sample <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				filtered_due.push_back(filter_sample(channel, sample));
				beats_in++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (samples_pending.size() != 0) begin
					drv_beat = samples_pending.pop_front();
					in_valid <= 1'b1;
					channel <= drv_beat.ch;
					sample <= drv_beat.x;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each output beat against the oldest prediction; stall on a shifting pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_due.size() == 0) begin
					log_mismatch("beat with nothing pending", filtered, '0);
				end else begin
					want = filtered_due.pop_front();
					if (filtered !== want)
						log_mismatch("filtered", filtered, want);
				end
				beats_out++;
			end
			stall_tick++;
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(16, 160);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no beat moved for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		mbl_pkg::order_t ord;
		logic [31:0] cf [5];
		int style;
		int n;
		foreach (fb_q[k])
			fb_q[k] = '0;
		foreach (hist[c, k])
			hist[c][k] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers at their reset values: bypass.
		queue_beat(2'd0, 32'h8000_0000);
		queue_beat(2'd1, 32'h7FFF_FFFF);
		queue_beat(2'd2, 32'h0000_0000);
		queue_beat(2'd3, 32'hFFFF_FFFF);
		wait_idle();

		set_config(mbl_pkg::ORD_FIRST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		queue_beat(2'd0, 32'h7FFF_FFFF);
		queue_beat(2'd0, 32'h7FFF_FFFF);
		queue_beat(2'd0, 32'h8000_0000);
		queue_beat(2'd3, 32'h8000_0000);
		queue_beat(2'd1, 32'h0000_0001);
		queue_beat(2'd2, 32'hFFFF_FFFF);
		wait_idle();

		// Drive the history word and the output into saturation.
		set_config(mbl_pkg::ORD_FOURTH, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_beat(2'd0, 32'h8000_0000);
		queue_beat(2'd0, 32'h8000_0000);
		queue_beat(2'd0, 32'h8000_0000);
		queue_beat(2'd0, 32'h7FFF_FFFF);
		queue_beat(2'd1, 32'h7FFF_FFFF);
		queue_beat(2'd1, 32'h7FFF_FFFF);
		queue_beat(2'd3, 32'h1234_5678);
		wait_idle();

		set_config(mbl_pkg::ORD_SECOND, G2_Q, A21_Q, A22_Q, 32'h0, 32'h0);
		repeat (4) queue_beat(2'd2, 32'h0001_0000);
		repeat (2) queue_beat(2'd0, 32'h0000_0000);
		wait_idle();

		while (queued < ITEM_TARGET) begin
			ord = ($urandom_range(0, 7) == 0) ? mbl_pkg::ORD_BYPASS :
				mbl_pkg::order_t'(2'($urandom_range(1, 3)));
			style = $urandom_range(0, 9);
			if (style < 2) begin
				foreach (cf[k])
					cf[k] = $urandom;
			end else if (style == 2) begin
				foreach (cf[k])
					cf[k] = pick_extreme();
			end else begin
				case (ord)
					mbl_pkg::ORD_FIRST:  cf = '{G1_Q, A1_Q, 32'h0, 32'h0, 32'h0};
					mbl_pkg::ORD_SECOND: cf = '{G2_Q, A21_Q, A22_Q, 32'h0, 32'h0};
					default:    cf = '{G4_Q, A41_Q, A42_Q, A43_Q, A44_Q};
				endcase
				foreach (cf[k])
					cf[k] = cf[k] + 32'($urandom_range(0, 511)) - 32'd256;
			end
			set_config(ord, cf[0], cf[1], cf[2], cf[3], cf[4]);
			n = $urandom_range(30, 150);
			repeat (n) queue_beat(rand_channel(), rand_sample());
			wait_idle();
		end

		repeat (20) @(negedge clk);
		$display("covered %0d input and %0d output beats over %0d register settings",
			beats_in, beats_out, phases);
		$display("%0d bypassed, %0d off-range channel, %0d/%0d/%0d first/second/fourth order",
			bypass_cnt, oor_cnt, ord_cnt[mbl_pkg::ORD_FIRST], ord_cnt[mbl_pkg::ORD_SECOND],
			ord_cnt[mbl_pkg::ORD_FOURTH]);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ multichannel_bessel_lowpass_iir_core.f @@
sv/mbl_pkg.sv
sv/mbl_cfg_regs.sv
sv/mbl_hist_mem.sv
sv/mbl_datapath.sv
sv/mbl_out_skid.sv
sv/multichannel_bessel_lowpass_iir_core.sv
tb/multichannel_bessel_lowpass_iir_core_test.sv
